FILE: rtl/fralu_pkg.sv
package fralu_pkg;

	// operand and result width
	localparam int WIDTH = 32;
	// bits of a shift count or step count over one operand word
	localparam int KW = $clog2(WIDTH);

	// command codes
	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_DIVI = 3'd4,
		CMD_RED  = 3'd5
	} cmd_t;

	// input item
	typedef struct packed {
		logic [2:0]              command;
		logic signed [WIDTH-1:0] a_num;
		logic signed [WIDTH-1:0] a_den;
		logic signed [WIDTH-1:0] b_num;
		logic signed [WIDTH-1:0] b_den;
		logic                    reduce;
	} req_t;

	// result item
	typedef struct packed {
		logic signed [WIDTH-1:0] result_num;
		logic signed [WIDTH-1:0] result_den;
		logic                    error;
	} res_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_AN_BD,
		MUL_BN_AD,
		MUL_AD_BD,
		MUL_AN_BN,
		MUL_AD_BN,
		MUL_AN_1,
		MUL_AD_1
	} mul_op_t;

	// product destination
	typedef enum logic [1:0] {
		DST_NONE,
		DST_NUM,
		DST_DEN,
		DST_TMP
	} dst_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_COMB,
		ST_CHECK,
		ST_GCD,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load;
		mul_op_t mul_op;
		dst_t    mul_dst;
		logic    comb;
		logic    comb_sub;
		logic    set_err;
		logic    set_zero;
		logic    gcd_init;
		logic    gcd_step;
		logic    div_init;
		logic    div_step;
		logic    fin;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic num_zero;
		logic den_zero;
		logic gcd_done;
		logic div_last;
	} stat_t;

endpackage

FILE: rtl/fralu_dp.sv
module fralu_dp (
	input  logic            clk,
	input  fralu_pkg::req_t request,
	input  fralu_pkg::ctl_t ctl,
	output fralu_pkg::stat_t stat,
	output fralu_pkg::res_t result
);

	localparam int W  = fralu_pkg::WIDTH;
	localparam int KW = fralu_pkg::KW;

	logic [W-1:0]   an_q, ad_q, bn_q, bd_q;
	logic [W-1:0]   num_q, den_q, tmp_q;
	logic           err_q;
	logic [W-1:0]   x_q, y_q, g_q;
	logic [KW-1:0]  k_q, cnt_q;
	logic [W-1:0]   qn_q, qd_q, rn_q, rd_q;

	logic [W-1:0]   mul_a, mul_b, prod;
	logic [2*W-1:0] prod_full;
	logic [W-1:0]   comb_val;
	logic [W-1:0]   mag_num, mag_den;
	logic [W-1:0]   x_nx, y_nx, x_dif, y_dif;
	logic [KW-1:0]  k_nx;
	logic [W:0]     rn_sh, rd_sh, rn_sub, rd_sub;
	logic           ge_n, ge_d;
	logic [W-1:0]   rn_nx, rd_nx;

	// shared multiplier, low word only (wraps like the operand type)
	always_comb begin
		mul_a = an_q;
		mul_b = W'(1);
		case (ctl.mul_op)
			fralu_pkg::MUL_AN_BD: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
			fralu_pkg::MUL_BN_AD: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			fralu_pkg::MUL_AD_BD: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
			fralu_pkg::MUL_AN_BN: begin
				mul_a = an_q;
				mul_b = bn_q;
			end
			fralu_pkg::MUL_AD_BN: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			fralu_pkg::MUL_AD_1: begin
				mul_a = ad_q;
				mul_b = W'(1);
			end
			default: begin
				mul_a = an_q;
				mul_b = W'(1);
			end
		endcase
	end

	assign prod_full = mul_a * mul_b;
	assign prod      = prod_full[W-1:0];

	// cross-product sum or difference
	assign comb_val = ctl.comb_sub ? (num_q - tmp_q) : (num_q + tmp_q);

	// magnitudes, most negative value maps to 2^(W-1) exactly
	assign mag_num = num_q[W-1] ? (W'(0) - num_q) : num_q;
	assign mag_den = den_q[W-1] ? (W'(0) - den_q) : den_q;

	// binary gcd step, odd-odd case subtracts and halves at once
	assign x_dif = x_q - y_q;
	assign y_dif = y_q - x_q;
	always_comb begin
		x_nx = x_q;
		y_nx = y_q;
		k_nx = k_q;
		if (!x_q[0] && !y_q[0]) begin
			x_nx = x_q >> 1;
			y_nx = y_q >> 1;
			k_nx = k_q + KW'(1);
		end else if (!x_q[0]) begin
			x_nx = x_q >> 1;
		end else if (!y_q[0]) begin
			y_nx = y_q >> 1;
		end else if (x_q >= y_q) begin
			x_nx = x_dif >> 1;
		end else begin
			y_nx = y_dif >> 1;
		end
	end

	// restoring division of both magnitudes by the gcd in lockstep
	assign rn_sh  = {rn_q, qn_q[W-1]};
	assign rd_sh  = {rd_q, qd_q[W-1]};
	assign rn_sub = rn_sh - {1'b0, g_q};
	assign rd_sub = rd_sh - {1'b0, g_q};
	assign ge_n   = rn_sh >= {1'b0, g_q};
	assign ge_d   = rd_sh >= {1'b0, g_q};
	assign rn_nx  = ge_n ? rn_sub[W-1:0] : rn_sh[W-1:0];
	assign rd_nx  = ge_d ? rd_sub[W-1:0] : rd_sh[W-1:0];

	// operand and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			an_q  <= request.a_num;
			ad_q  <= request.a_den;
			bn_q  <= request.b_num;
			bd_q  <= request.b_den;
			err_q <= 1'b0;
		end
		case (ctl.mul_dst)
			fralu_pkg::DST_NUM: num_q <= prod;
			fralu_pkg::DST_DEN: den_q <= prod;
			fralu_pkg::DST_TMP: tmp_q <= prod;
			default: ;
		endcase
		if (ctl.comb)
			num_q <= comb_val;
		if (ctl.set_err)
			err_q <= 1'b1;
		if (ctl.set_zero) begin
			num_q <= W'(0);
			den_q <= W'(1);
		end
		if (ctl.fin) begin
			num_q <= num_q[W-1] ? (W'(0) - qn_q) : qn_q;
			den_q <= den_q[W-1] ? (W'(0) - qd_q) : qd_q;
		end
	end

	// gcd and divider registers
	always_ff @(posedge clk) begin
		if (ctl.gcd_init) begin
			x_q <= mag_num;
			y_q <= mag_den;
			k_q <= '0;
		end else if (ctl.gcd_step) begin
			x_q <= x_nx;
			y_q <= y_nx;
			k_q <= k_nx;
		end
		if (ctl.div_init) begin
			g_q   <= (x_q | y_q) << k_q;
			qn_q  <= mag_num;
			qd_q  <= mag_den;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			qn_q  <= {qn_q[W-2:0], ge_n};
			qd_q  <= {qd_q[W-2:0], ge_d};
			rn_q  <= rn_nx;
			rd_q  <= rd_nx;
			cnt_q <= cnt_q + KW'(1);
		end
	end

	// status back to the controller
	assign stat.num_zero = (num_q == '0);
	assign stat.den_zero = (den_q == '0);
	assign stat.gcd_done = (x_q == '0) || (y_q == '0);
	assign stat.div_last = (cnt_q == KW'(W - 1));

	assign result.result_num = num_q;
	assign result.result_den = den_q;
	assign result.error      = err_q;

endmodule

FILE: rtl/fralu_ctrl.sv
module fralu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       command,
	input  logic             reduce,
	input  fralu_pkg::stat_t stat,
	output fralu_pkg::ctl_t  ctl,
	output logic             busy,
	output logic             done
);

	fralu_pkg::state_t state_q, state_d;
	fralu_pkg::cmd_t   cmd_q;
	logic              red_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fralu_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// latched command, codes above reduce-only act as reduce-only
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= fralu_pkg::cmd_t'(command);
			red_q <= reduce || (command >= fralu_pkg::CMD_RED);
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.mul_op  = fralu_pkg::MUL_AN_1;
		ctl.mul_dst = fralu_pkg::DST_NONE;
		unique case (state_q)
			fralu_pkg::ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = fralu_pkg::ST_M1;
				end
			end
			fralu_pkg::ST_M1: begin
				ctl.mul_dst = fralu_pkg::DST_NUM;
				unique case (cmd_q) inside
					fralu_pkg::CMD_ADD, fralu_pkg::CMD_SUB, fralu_pkg::CMD_DIV:
						ctl.mul_op = fralu_pkg::MUL_AN_BD;
					fralu_pkg::CMD_MUL:
						ctl.mul_op = fralu_pkg::MUL_AN_BN;
					default:
						ctl.mul_op = fralu_pkg::MUL_AN_1;
				endcase
				state_d = fralu_pkg::ST_M2;
			end
			fralu_pkg::ST_M2: begin
				state_d = fralu_pkg::ST_CHECK;
				unique case (cmd_q) inside
					fralu_pkg::CMD_ADD, fralu_pkg::CMD_SUB: begin
						ctl.mul_op  = fralu_pkg::MUL_BN_AD;
						ctl.mul_dst = fralu_pkg::DST_TMP;
						state_d     = fralu_pkg::ST_M3;
					end
					fralu_pkg::CMD_DIV: begin
						ctl.mul_op  = fralu_pkg::MUL_BN_AD;
						ctl.mul_dst = fralu_pkg::DST_DEN;
					end
					fralu_pkg::CMD_MUL: begin
						ctl.mul_op  = fralu_pkg::MUL_AD_BD;
						ctl.mul_dst = fralu_pkg::DST_DEN;
					end
					fralu_pkg::CMD_DIVI: begin
						ctl.mul_op  = fralu_pkg::MUL_AD_BN;
						ctl.mul_dst = fralu_pkg::DST_DEN;
					end
					default: begin
						ctl.mul_op  = fralu_pkg::MUL_AD_1;
						ctl.mul_dst = fralu_pkg::DST_DEN;
					end
				endcase
			end
			fralu_pkg::ST_M3: begin
				ctl.mul_op  = fralu_pkg::MUL_AD_BD;
				ctl.mul_dst = fralu_pkg::DST_DEN;
				state_d     = fralu_pkg::ST_COMB;
			end
			fralu_pkg::ST_COMB: begin
				ctl.comb     = 1'b1;
				ctl.comb_sub = (cmd_q == fralu_pkg::CMD_SUB);
				state_d      = fralu_pkg::ST_CHECK;
			end
			fralu_pkg::ST_CHECK: begin
				if (!red_q) begin
					state_d = fralu_pkg::ST_DONE;
				end else if (stat.den_zero) begin
					ctl.set_err = 1'b1;
					state_d     = fralu_pkg::ST_DONE;
				end else if (stat.num_zero) begin
					ctl.set_zero = 1'b1;
					state_d      = fralu_pkg::ST_DONE;
				end else begin
					ctl.gcd_init = 1'b1;
					state_d      = fralu_pkg::ST_GCD;
				end
			end
			fralu_pkg::ST_GCD: begin
				if (stat.gcd_done) begin
					ctl.div_init = 1'b1;
					state_d      = fralu_pkg::ST_DIV;
				end else begin
					ctl.gcd_step = 1'b1;
				end
			end
			fralu_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last)
					state_d = fralu_pkg::ST_FIN;
			end
			fralu_pkg::ST_FIN: begin
				ctl.fin = 1'b1;
				state_d = fralu_pkg::ST_DONE;
			end
			fralu_pkg::ST_DONE: begin
				state_d = fralu_pkg::ST_IDLE;
			end
			default: begin
				state_d = fralu_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != fralu_pkg::ST_IDLE);
	assign done = (state_q == fralu_pkg::ST_DONE);

endmodule

FILE: rtl/fraction_alu_with_reduction.sv
// sequence: after accept the products, a combine step for add or sub, then a check;
//   done without reduction or for a zero part, else a binary gcd of up to 2*WIDTH
//   steps and WIDTH steps of the restoring divider on both parts at once, then done
// throughput: one item at a time, start is taken again the cycle after done
// done is a single-cycle strobe, the receiver cannot stall the result
// reset: arst_n asynchronous active low, returns the controller to idle
module fraction_alu_with_reduction (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  fralu_pkg::req_t request,
	output logic            busy,
	output logic            done,
	output fralu_pkg::res_t result
);

	fralu_pkg::ctl_t  ctl;
	fralu_pkg::stat_t stat;

	// sequencer
	fralu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.reduce  (request.reduce),
		.stat    (stat),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done)
	);

	// multiplier, gcd and divider
	fralu_dp u_dp (
		.clk     (clk),
		.request (request),
		.ctl     (ctl),
		.stat    (stat),
		.result  (result)
	);

endmodule

FILE: rtl/fralu_chk.sv
module fralu_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input fralu_pkg::req_t request,
	input logic            busy,
	input logic            done,
	input fralu_pkg::res_t result
);

	// an accepted item keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only appears while an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without an item in flight");

	// result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// error only comes with a zero denominator passed through
	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error |-> result.result_den == '0)
		else $error("error flagged with nonzero denominator");

endmodule

bind fraction_alu_with_reduction fralu_chk u_chk (.*);
